// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ----- design/mrs_pkg.sv -----
// Shared types, codes and CRC helper for the Modbus RTU slave engine.
// No dependencies.
package mrs_pkg;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  rx_byte;
		logic        frame_end;
		logic [7:0]  load_index;
		logic [15:0] load_value;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       tx_last;
		logic [2:0] status;
	} rsp_t;

	localparam logic [1:0] FUNC_RX        = 2'd0;
	localparam logic [1:0] FUNC_LOAD_IREG = 2'd1;
	localparam logic [1:0] FUNC_SET_DISC  = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_CRC   = 3'd2;
	localparam logic [2:0] ST_ADDR  = 3'd3;
	localparam logic [2:0] ST_FUNC  = 3'd4;
	localparam logic [2:0] ST_VALUE = 3'd5;

	localparam logic [7:0] FC_RD_COILS = 8'd1;
	localparam logic [7:0] FC_RD_DISC  = 8'd2;
	localparam logic [7:0] FC_RD_HOLD  = 8'd3;
	localparam logic [7:0] FC_RD_IREG  = 8'd4;
	localparam logic [7:0] FC_WR_COIL  = 8'd5;
	localparam logic [7:0] FC_WR_REG   = 8'd6;
	localparam logic [7:0] FC_WR_COILS = 8'd15;
	localparam logic [7:0] FC_WR_REGS  = 8'd16;

	localparam logic [1:0] CFG_HOLD = 2'd0;
	localparam logic [1:0] CFG_IREG = 2'd1;
	localparam logic [1:0] CFG_COIL = 2'd2;
	localparam logic [1:0] CFG_DISC = 2'd3;
	localparam int         CFG_W    = 9;

	localparam logic [6:0] HOLD_CNT_RST = 7'd64;
	localparam logic [6:0] IREG_CNT_RST = 7'd64;
	localparam logic [8:0] COIL_CNT_RST = 9'd256;
	localparam logic [8:0] DISC_CNT_RST = 9'd256;

	localparam logic [15:0] CRC_SEED  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] COIL_ON   = 16'hFF00;
	localparam logic [15:0] COIL_OFF  = 16'h0000;
	localparam int          MIN_FRAME = 8;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_EVAL, S_ID, S_FC, S_BC,
		S_BRD, S_BACC, S_BEMIT, S_WRD, S_WHI, S_WLO,
		S_W5, S_W6, S_CRD, S_CWR, S_HRD1, S_HRD2, S_HWR,
		S_ECHO0, S_ECHO1, S_ECHO2, S_ECHO3, S_CRCLO, S_CRCHI, S_FIN
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_CLR, OP_CHECK, OP_RD_BIT, OP_ACC_BIT, OP_RD_WORD, OP_NEXT,
		OP_RD_RXB, OP_WR_COILB, OP_WR_COIL1, OP_WR_HOLD1, OP_RD_RXHI, OP_RD_RXLO,
		OP_WR_HOLDW, OP_RX_CLEAR
	} dp_op_t;

	typedef enum logic [3:0] {
		E_FAIL, E_ID, E_FC, E_BC, E_ACC, E_RDHI, E_RDLO,
		E_ADDRHI, E_ADDRLO, E_QHI, E_QLO, E_CRCLO, E_CRCHI
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		dp_op_t    op;
		logic      emit;
		emit_sel_t sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic       out_free;
		logic [2:0] err;
		logic [7:0] fc;
		logic       idx_done;
		logic       idx_last;
		logic       bit7;
		logic       clr_last;
	} dp_sts_t;

	// one byte of CRC-16, reflected
	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

// ----- design/mrs_dp.sv -----
// Datapath: receive store, data stores, frame checks, response byte builder.
// Depends on mrs_pkg.
module mrs_dp #(
	parameter int HOLD_REGS      = 64,
	parameter int INPUT_REGS     = 64,
	parameter int COILS          = 256,
	parameter int DISCRETES      = 256,
	parameter int RX_BYTES       = 72,
	parameter int MAX_READ_WORDS = 28
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mrs_pkg::ctrl_cmd_t         cmd,
	input  mrs_pkg::req_t              req,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [mrs_pkg::CFG_W-1:0]  cfg_data,
	output mrs_pkg::dp_sts_t           sts,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output mrs_pkg::rsp_t              rsp
);
	localparam int HW = (HOLD_REGS > 1) ? $clog2(HOLD_REGS) : 1;
	localparam int IW = (INPUT_REGS > 1) ? $clog2(INPUT_REGS) : 1;
	localparam int CW = (COILS > 1) ? $clog2(COILS) : 1;
	localparam int DW = (DISCRETES > 1) ? $clog2(DISCRETES) : 1;
	localparam int RW = $clog2(RX_BYTES);
	localparam int FW = $clog2(RX_BYTES + 1);
	localparam int CLR_A = (HOLD_REGS > INPUT_REGS) ? HOLD_REGS : INPUT_REGS;
	localparam int CLR_B = (COILS > DISCRETES) ? COILS : DISCRETES;
	localparam int CLR_N = (CLR_A > CLR_B) ? CLR_A : CLR_B;

	// config
	logic [6:0] hold_cnt_q, ireg_cnt_q;
	logic [8:0] coil_cnt_q, disc_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cnt_q <= mrs_pkg::HOLD_CNT_RST;
			ireg_cnt_q <= mrs_pkg::IREG_CNT_RST;
			coil_cnt_q <= mrs_pkg::COIL_CNT_RST;
			disc_cnt_q <= mrs_pkg::DISC_CNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mrs_pkg::CFG_HOLD: hold_cnt_q <= cfg_data[6:0];
				mrs_pkg::CFG_IREG: ireg_cnt_q <= cfg_data[6:0];
				mrs_pkg::CFG_COIL: coil_cnt_q <= cfg_data;
				mrs_pkg::CFG_DISC: disc_cnt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// receive side
	logic [FW-1:0] fill_q;
	logic          ovf_q;
	logic [15:0]   rcrc_q;
	logic [7:0]    sh1_q, sh2_q;
	logic [7:0]    id_q, fc_q, bc_q;
	logic [15:0]   addr_q, q_q;
	logic          is_rx, rx_we;

	assign is_rx = (req.func == mrs_pkg::FUNC_RX);
	assign rx_we = cmd.accept && is_rx && (fill_q != FW'(RX_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			rcrc_q <= mrs_pkg::CRC_SEED;
		end else if (cmd.op == mrs_pkg::OP_RX_CLEAR) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			rcrc_q <= mrs_pkg::CRC_SEED;
		end else if (cmd.accept && is_rx) begin
			if (rx_we) begin
				fill_q <= fill_q + 1'b1;
				// CRC trails by two bytes so the frame's own CRC stays out
				if (fill_q >= FW'(2))
					rcrc_q <= mrs_pkg::crc16_byte(rcrc_q, sh2_q);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			sh1_q <= req.rx_byte;
			sh2_q <= sh1_q;
			if (fill_q == FW'(0)) id_q <= req.rx_byte;
			if (fill_q == FW'(1)) fc_q <= req.rx_byte;
			if (fill_q == FW'(2)) addr_q[15:8] <= req.rx_byte;
			if (fill_q == FW'(3)) addr_q[7:0] <= req.rx_byte;
			if (fill_q == FW'(4)) q_q[15:8] <= req.rx_byte;
			if (fill_q == FW'(5)) q_q[7:0] <= req.rx_byte;
			if (fill_q == FW'(6)) bc_q <= req.rx_byte;
		end
	end

	// walk counter
	logic [15:0] idx_q;
	logic [16:0] eaddr;

	assign eaddr = {1'b0, addr_q} + {1'b0, idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else begin
			case (cmd.op)
				mrs_pkg::OP_CHECK: idx_q <= '0;
				mrs_pkg::OP_CLR, mrs_pkg::OP_ACC_BIT, mrs_pkg::OP_NEXT,
				mrs_pkg::OP_WR_COILB, mrs_pkg::OP_WR_HOLDW: idx_q <= idx_q + 16'd1;
				default: ;
			endcase
		end
	end

	// rx store
	logic [7:0]  rx_mem [RX_BYTES];
	logic [7:0]  rx_rd_q;
	logic        rx_re;
	logic [16:0] rx_ra;

	always_comb begin
		rx_re = 1'b1;
		case (cmd.op)
			mrs_pkg::OP_RD_RXB:  rx_ra = 17'd7 + {4'd0, idx_q[15:3]};
			mrs_pkg::OP_RD_RXHI: rx_ra = 17'd7 + {idx_q, 1'b0};
			mrs_pkg::OP_RD_RXLO: rx_ra = 17'd8 + {idx_q, 1'b0};
			default: begin
				rx_re = 1'b0;
				rx_ra = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rx_we)
			rx_mem[fill_q[RW-1:0]] <= req.rx_byte;
		if (rx_re)
			rx_rd_q <= rx_mem[rx_ra[RW-1:0]];
	end

	logic [7:0] hi_q;
	always_ff @(posedge clk) begin
		if (cmd.op == mrs_pkg::OP_RD_RXLO)
			hi_q <= rx_rd_q;
	end

	logic        clr;
	logic [15:0] lidx;
	assign clr  = (cmd.op == mrs_pkg::OP_CLR);
	assign lidx = {8'h00, req.load_index};

	// holding registers
	logic [15:0] hold_mem [HOLD_REGS];
	logic [15:0] hold_rd_q, hold_wd;
	logic [HW-1:0] hold_wa;
	logic        hold_we;

	always_comb begin
		hold_we = 1'b0;
		hold_wa = eaddr[HW-1:0];
		hold_wd = {hi_q, rx_rd_q};
		case (cmd.op)
			mrs_pkg::OP_CLR: begin
				hold_we = (idx_q < 16'(HOLD_REGS));
				hold_wa = idx_q[HW-1:0];
				hold_wd = '0;
			end
			mrs_pkg::OP_WR_HOLD1: begin
				hold_we = 1'b1;
				hold_wa = addr_q[HW-1:0];
				hold_wd = q_q;
			end
			mrs_pkg::OP_WR_HOLDW: hold_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (hold_we)
			hold_mem[hold_wa] <= hold_wd;
		if (cmd.op == mrs_pkg::OP_RD_WORD)
			hold_rd_q <= hold_mem[eaddr[HW-1:0]];
	end

	// input registers
	logic [15:0] ireg_mem [INPUT_REGS];
	logic [15:0] ireg_rd_q;
	logic        ireg_ld;

	assign ireg_ld = cmd.accept && (req.func == mrs_pkg::FUNC_LOAD_IREG)
		&& (lidx < 16'(INPUT_REGS));

	always_ff @(posedge clk) begin
		if (clr && (idx_q < 16'(INPUT_REGS)))
			ireg_mem[idx_q[IW-1:0]] <= '0;
		else if (ireg_ld)
			ireg_mem[lidx[IW-1:0]] <= req.load_value;
		if (cmd.op == mrs_pkg::OP_RD_WORD)
			ireg_rd_q <= ireg_mem[eaddr[IW-1:0]];
	end

	// coils
	logic coil_mem [COILS];
	logic coil_rd_q;

	always_ff @(posedge clk) begin
		if (clr && (idx_q < 16'(COILS)))
			coil_mem[idx_q[CW-1:0]] <= 1'b0;
		else if (cmd.op == mrs_pkg::OP_WR_COIL1)
			coil_mem[addr_q[CW-1:0]] <= (q_q == mrs_pkg::COIL_ON);
		else if (cmd.op == mrs_pkg::OP_WR_COILB)
			coil_mem[eaddr[CW-1:0]] <= rx_rd_q[idx_q[2:0]];
		if (cmd.op == mrs_pkg::OP_RD_BIT)
			coil_rd_q <= coil_mem[eaddr[CW-1:0]];
	end

	// discrete inputs
	logic disc_mem [DISCRETES];
	logic disc_rd_q;
	logic disc_ld;

	assign disc_ld = cmd.accept && (req.func == mrs_pkg::FUNC_SET_DISC)
		&& (lidx < 16'(DISCRETES));

	always_ff @(posedge clk) begin
		if (clr && (idx_q < 16'(DISCRETES)))
			disc_mem[idx_q[DW-1:0]] <= 1'b0;
		else if (disc_ld)
			disc_mem[lidx[DW-1:0]] <= req.load_value[0];
		if (cmd.op == mrs_pkg::OP_RD_BIT)
			disc_rd_q <= disc_mem[eaddr[DW-1:0]];
	end

	// frame checks
	logic [16:0] sumq, m_hold, m_ireg, m_coil, m_disc, bcq, len17;
	logic        crc_ok, bc_short;
	logic [2:0]  chk, err_q;

	assign sumq   = {1'b0, addr_q} + {1'b0, q_q};
	assign m_hold = (17'(hold_cnt_q) < 17'(HOLD_REGS)) ? 17'(hold_cnt_q) : 17'(HOLD_REGS);
	assign m_ireg = (17'(ireg_cnt_q) < 17'(INPUT_REGS)) ? 17'(ireg_cnt_q) : 17'(INPUT_REGS);
	assign m_coil = (17'(coil_cnt_q) < 17'(COILS)) ? 17'(coil_cnt_q) : 17'(COILS);
	assign m_disc = (17'(disc_cnt_q) < 17'(DISCRETES)) ? 17'(disc_cnt_q) : 17'(DISCRETES);
	assign bcq    = ({1'b0, q_q} + 17'd7) >> 3;
	assign len17  = 17'(fill_q);
	assign crc_ok = ({sh1_q, sh2_q} == rcrc_q);
	assign bc_short = ((17'(bc_q) + 17'd9) > len17);

	always_comb begin
		chk = mrs_pkg::ST_OK;
		if (ovf_q || (len17 < 17'(mrs_pkg::MIN_FRAME))) begin
			chk = mrs_pkg::ST_VALUE;
		end else if (!crc_ok) begin
			chk = mrs_pkg::ST_CRC;
		end else begin
			case (fc_q)
				mrs_pkg::FC_RD_COILS, mrs_pkg::FC_RD_DISC: begin
					if (sumq > ((fc_q == mrs_pkg::FC_RD_COILS) ? m_coil : m_disc))
						chk = mrs_pkg::ST_ADDR;
					else if (bcq > 17'(2 * MAX_READ_WORDS))
						chk = mrs_pkg::ST_VALUE;
				end
				mrs_pkg::FC_RD_HOLD, mrs_pkg::FC_RD_IREG: begin
					if (sumq > ((fc_q == mrs_pkg::FC_RD_HOLD) ? m_hold : m_ireg))
						chk = mrs_pkg::ST_ADDR;
					else if ({1'b0, q_q} > 17'(MAX_READ_WORDS))
						chk = mrs_pkg::ST_VALUE;
				end
				mrs_pkg::FC_WR_COIL: begin
					if ({1'b0, addr_q} >= m_coil)
						chk = mrs_pkg::ST_ADDR;
					else if ((q_q != mrs_pkg::COIL_OFF) && (q_q != mrs_pkg::COIL_ON))
						chk = mrs_pkg::ST_VALUE;
				end
				mrs_pkg::FC_WR_REG: begin
					if ({1'b0, addr_q} >= m_hold)
						chk = mrs_pkg::ST_ADDR;
				end
				mrs_pkg::FC_WR_COILS: begin
					if (sumq > m_coil)
						chk = mrs_pkg::ST_ADDR;
					else if ((17'(bc_q) != bcq) || bc_short)
						chk = mrs_pkg::ST_VALUE;
				end
				mrs_pkg::FC_WR_REGS: begin
					if (sumq > m_hold)
						chk = mrs_pkg::ST_ADDR;
					else if ((17'(bc_q) != {q_q, 1'b0}) || bc_short)
						chk = mrs_pkg::ST_VALUE;
				end
				default: chk = mrs_pkg::ST_FUNC;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			err_q <= mrs_pkg::ST_OK;
		else if (cmd.op == mrs_pkg::OP_CHECK)
			err_q <= chk;
	end

	// bit packing for coil / discrete reads
	logic [7:0] acc_q;
	always_ff @(posedge clk) begin
		if (cmd.op == mrs_pkg::OP_CHECK)
			acc_q <= '0;
		else if (cmd.op == mrs_pkg::OP_ACC_BIT)
			acc_q[idx_q[2:0]] <= (fc_q == mrs_pkg::FC_RD_COILS) ? coil_rd_q : disc_rd_q;
		else if (cmd.emit && (cmd.sel == mrs_pkg::E_ACC))
			acc_q <= '0;
	end

	// response byte select
	logic [15:0] rdw;
	logic [15:0] tcrc_q;
	logic [7:0]  ebyte;
	logic        crc_byte, fail;

	assign rdw = (fc_q == mrs_pkg::FC_RD_HOLD) ? hold_rd_q : ireg_rd_q;

	always_comb begin
		case (cmd.sel)
			mrs_pkg::E_ID:     ebyte = id_q;
			mrs_pkg::E_FC:     ebyte = fc_q;
			mrs_pkg::E_BC:     ebyte = ((fc_q == mrs_pkg::FC_RD_COILS)
				|| (fc_q == mrs_pkg::FC_RD_DISC)) ? bcq[7:0] : {q_q[6:0], 1'b0};
			mrs_pkg::E_ACC:    ebyte = acc_q;
			mrs_pkg::E_RDHI:   ebyte = rdw[15:8];
			mrs_pkg::E_RDLO:   ebyte = rdw[7:0];
			mrs_pkg::E_ADDRHI: ebyte = addr_q[15:8];
			mrs_pkg::E_ADDRLO: ebyte = addr_q[7:0];
			mrs_pkg::E_QHI:    ebyte = q_q[15:8];
			mrs_pkg::E_QLO:    ebyte = q_q[7:0];
			mrs_pkg::E_CRCLO:  ebyte = tcrc_q[7:0];
			mrs_pkg::E_CRCHI:  ebyte = tcrc_q[15:8];
			default:           ebyte = 8'h00;
		endcase
	end

	assign fail     = (cmd.sel == mrs_pkg::E_FAIL);
	assign crc_byte = (cmd.sel == mrs_pkg::E_CRCLO) || (cmd.sel == mrs_pkg::E_CRCHI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tcrc_q <= mrs_pkg::CRC_SEED;
		else if (cmd.op == mrs_pkg::OP_CHECK)
			tcrc_q <= mrs_pkg::CRC_SEED;
		else if (cmd.emit && !fail && !crc_byte)
			tcrc_q <= mrs_pkg::crc16_byte(tcrc_q, ebyte);
	end

	// output register
	logic          rsp_valid_q;
	mrs_pkg::rsp_t rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (cmd.emit)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.tx_byte  <= ebyte;
			rsp_q.tx_valid <= !fail;
			rsp_q.tx_last  <= fail || (cmd.sel == mrs_pkg::E_CRCHI);
			rsp_q.status   <= fail ? err_q : mrs_pkg::ST_OK;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign sts.out_free = !rsp_valid_q || !rsp_stall;
	assign sts.err      = err_q;
	assign sts.fc       = fc_q;
	assign sts.idx_done = (idx_q == q_q);
	assign sts.idx_last = ((idx_q + 16'd1) == q_q);
	assign sts.bit7     = (idx_q[2:0] == 3'd7);
	assign sts.clr_last = (idx_q == 16'(CLR_N - 1));

endmodule

// ----- design/mrs_ctrl.sv -----
// Controller: sequences clearing, frame checks, store updates and response beats.
// Depends on mrs_pkg.
module mrs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  mrs_pkg::req_t      req,
	output logic               req_stall,
	input  mrs_pkg::dp_sts_t   sts,
	output mrs_pkg::ctrl_cmd_t cmd
);
	mrs_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mrs_pkg::S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		cmd.accept = 1'b0;
		cmd.op     = mrs_pkg::OP_NONE;
		cmd.emit   = 1'b0;
		cmd.sel    = mrs_pkg::E_FAIL;
		case (state_q)
			mrs_pkg::S_CLEAR: begin
				cmd.op = mrs_pkg::OP_CLR;
				if (sts.clr_last)
					state_d = mrs_pkg::S_IDLE;
			end
			mrs_pkg::S_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
				if (req_valid && (req.func == mrs_pkg::FUNC_RX) && req.frame_end)
					state_d = mrs_pkg::S_CHECK;
			end
			mrs_pkg::S_CHECK: begin
				cmd.op  = mrs_pkg::OP_CHECK;
				state_d = mrs_pkg::S_EVAL;
			end
			mrs_pkg::S_EVAL: begin
				if (sts.err != mrs_pkg::ST_OK) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						cmd.sel  = mrs_pkg::E_FAIL;
						state_d  = mrs_pkg::S_FIN;
					end
				end else begin
					state_d = mrs_pkg::S_ID;
				end
			end
			mrs_pkg::S_ID: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_ID;
				state_d  = mrs_pkg::S_FC;
			end
			mrs_pkg::S_FC: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_FC;
				case (sts.fc)
					mrs_pkg::FC_RD_COILS, mrs_pkg::FC_RD_DISC,
					mrs_pkg::FC_RD_HOLD, mrs_pkg::FC_RD_IREG: state_d = mrs_pkg::S_BC;
					mrs_pkg::FC_WR_COIL: state_d = mrs_pkg::S_W5;
					mrs_pkg::FC_WR_REG:  state_d = mrs_pkg::S_W6;
					mrs_pkg::FC_WR_COILS:
						state_d = sts.idx_done ? mrs_pkg::S_ECHO0 : mrs_pkg::S_CRD;
					mrs_pkg::FC_WR_REGS:
						state_d = sts.idx_done ? mrs_pkg::S_ECHO0 : mrs_pkg::S_HRD1;
					default: state_d = mrs_pkg::S_CRCLO;
				endcase
			end
			mrs_pkg::S_BC: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_BC;
				if (sts.idx_done)
					state_d = mrs_pkg::S_CRCLO;
				else if ((sts.fc == mrs_pkg::FC_RD_COILS) || (sts.fc == mrs_pkg::FC_RD_DISC))
					state_d = mrs_pkg::S_BRD;
				else
					state_d = mrs_pkg::S_WRD;
			end
			mrs_pkg::S_BRD: begin
				cmd.op  = mrs_pkg::OP_RD_BIT;
				state_d = mrs_pkg::S_BACC;
			end
			mrs_pkg::S_BACC: begin
				cmd.op  = mrs_pkg::OP_ACC_BIT;
				state_d = (sts.idx_last || sts.bit7) ? mrs_pkg::S_BEMIT : mrs_pkg::S_BRD;
			end
			mrs_pkg::S_BEMIT: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_ACC;
				state_d  = sts.idx_done ? mrs_pkg::S_CRCLO : mrs_pkg::S_BRD;
			end
			mrs_pkg::S_WRD: begin
				cmd.op  = mrs_pkg::OP_RD_WORD;
				state_d = mrs_pkg::S_WHI;
			end
			mrs_pkg::S_WHI: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_RDHI;
				state_d  = mrs_pkg::S_WLO;
			end
			mrs_pkg::S_WLO: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_RDLO;
				cmd.op   = mrs_pkg::OP_NEXT;
				state_d  = sts.idx_last ? mrs_pkg::S_CRCLO : mrs_pkg::S_WRD;
			end
			mrs_pkg::S_W5: begin
				cmd.op  = mrs_pkg::OP_WR_COIL1;
				state_d = mrs_pkg::S_ECHO0;
			end
			mrs_pkg::S_W6: begin
				cmd.op  = mrs_pkg::OP_WR_HOLD1;
				state_d = mrs_pkg::S_ECHO0;
			end
			mrs_pkg::S_CRD: begin
				cmd.op  = mrs_pkg::OP_RD_RXB;
				state_d = mrs_pkg::S_CWR;
			end
			mrs_pkg::S_CWR: begin
				cmd.op = mrs_pkg::OP_WR_COILB;
				if (sts.idx_last)
					state_d = mrs_pkg::S_ECHO0;
				else if (sts.bit7)
					state_d = mrs_pkg::S_CRD;
			end
			mrs_pkg::S_HRD1: begin
				cmd.op  = mrs_pkg::OP_RD_RXHI;
				state_d = mrs_pkg::S_HRD2;
			end
			mrs_pkg::S_HRD2: begin
				cmd.op  = mrs_pkg::OP_RD_RXLO;
				state_d = mrs_pkg::S_HWR;
			end
			mrs_pkg::S_HWR: begin
				cmd.op  = mrs_pkg::OP_WR_HOLDW;
				state_d = sts.idx_last ? mrs_pkg::S_ECHO0 : mrs_pkg::S_HRD1;
			end
			mrs_pkg::S_ECHO0: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_ADDRHI;
				state_d  = mrs_pkg::S_ECHO1;
			end
			mrs_pkg::S_ECHO1: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_ADDRLO;
				state_d  = mrs_pkg::S_ECHO2;
			end
			mrs_pkg::S_ECHO2: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_QHI;
				state_d  = mrs_pkg::S_ECHO3;
			end
			mrs_pkg::S_ECHO3: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_QLO;
				state_d  = mrs_pkg::S_CRCLO;
			end
			mrs_pkg::S_CRCLO: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_CRCLO;
				state_d  = mrs_pkg::S_CRCHI;
			end
			mrs_pkg::S_CRCHI: if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.sel  = mrs_pkg::E_CRCHI;
				state_d  = mrs_pkg::S_FIN;
			end
			mrs_pkg::S_FIN: begin
				cmd.op  = mrs_pkg::OP_RX_CLEAR;
				state_d = mrs_pkg::S_IDLE;
			end
			default: state_d = mrs_pkg::S_IDLE;
		endcase
	end

endmodule

// ----- design/modbus_rtu_slave_engine.sv -----
// Top level of the Modbus RTU slave engine: controller plus datapath.
// Depends on mrs_pkg, mrs_ctrl, mrs_dp and assert_macros.svh.
//
//   channel  direction  payload          handshake
//   req      in         mrs_pkg::req_t   req_valid / req_stall
//   rsp      out        mrs_pkg::rsp_t   rsp_valid / rsp_stall
//   cfg      in         cfg_index/data   cfg_we, no wait
//
// A frame end byte starts a serve pass: checking, then one beat per response
// byte (a single error beat if a check fails), then a clear of the receive
// state. Bit reads read and pack each coil or input, then emit each data byte;
// register reads read each word, then emit its high and low bytes; multiple
// coil writes fetch each data byte, then write its coils; register writes fetch
// each word's two bytes, then write it. req is stalled during a pass.
// After reset a clearing pass zeroes the stores, one entry a cycle over the
// deepest store, with req stalled.
// A stalled rsp beat holds; the pass waits on it.
`include "assert_macros.svh"

module modbus_rtu_slave_engine #(
	parameter int HOLD_REGS      = 64,
	parameter int INPUT_REGS     = 64,
	parameter int COILS          = 256,
	parameter int DISCRETES      = 256,
	parameter int RX_BYTES       = 72,
	parameter int MAX_READ_WORDS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  mrs_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output mrs_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [mrs_pkg::CFG_W-1:0] cfg_data
);
	mrs_pkg::ctrl_cmd_t cmd;
	mrs_pkg::dp_sts_t   sts;

	mrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mrs_dp #(
		.HOLD_REGS      (HOLD_REGS),
		.INPUT_REGS     (INPUT_REGS),
		.COILS          (COILS),
		.DISCRETES      (DISCRETES),
		.RX_BYTES       (RX_BYTES),
		.MAX_READ_WORDS (MAX_READ_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// an error beat is alone: no byte, frame closed
	`ASSERT_IMPL(a_fail_beat, rsp_valid && (rsp.status != mrs_pkg::ST_OK), !rsp.tx_valid && rsp.tx_last, "error beat carries a byte or is not last")
	// a beat without a byte always carries an error
	`ASSERT_IMPL(a_nobyte_err, rsp_valid && !rsp.tx_valid, rsp.status != mrs_pkg::ST_OK, "empty beat with ok status")
	// a frame end starts a serve pass, so the input closes next cycle
	`ASSERT_NEXT(a_fe_busy, req_valid && !req_stall && (req.func == mrs_pkg::FUNC_RX) && req.frame_end, req_stall, "request taken during serve")
	// emits only go out when the output register can take them
	`ASSERT_IMPL(a_emit_free, cmd.emit, sts.out_free, "beat overwritten while stalled")

endmodule
